>>> rtl/ffcss_pkg.sv
package ffcss_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FILTER = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [2:0] REG_WIDTH_CODE = 3'd0;
  localparam logic [2:0] REG_FIRST_DATA = 3'd1;
  localparam logic [2:0] REG_SPC        = 3'd2;
  localparam logic [2:0] REG_COUNT      = 3'd3;
  localparam logic [2:0] REG_TOTAL      = 3'd4;

  localparam logic [1:0] FMT_FAT12 = 2'd0;
  localparam logic [1:0] FMT_FAT16 = 2'd1;

  localparam logic [27:0] MASK28 = 28'hFFFFFFF;
  localparam logic [11:0] MASK12 = 12'hFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [19:0] table_address;
    logic [7:0]  table_byte;
    logic [31:0] sector_index;
    logic [63:0] data_word;
    logic        end_of_sector;
  } in_item_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic        zeroed;
    logic        out_of_store;
    logic [31:0] imaged_sectors;
    logic [27:0] highest_used_cluster;
    logic        sector_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [19:0] table_address;
    logic [7:0]  table_byte;
    logic [31:0] sector_index;
    logic [63:0] data_word;
    logic        end_of_sector;
  } queue_item_t;

  typedef struct packed {
    logic [1:0]  width_code;
    logic [31:0] first_data;
    logic [7:0]  spc;
    logic [27:0] count;
    logic [31:0] total;
  } cfg_t;

endpackage

>>> rtl/ffcss_if.sv
interface ffcss_in_if;
  logic valid;
  logic ready;
  ffcss_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ffcss_out_if;
  logic valid;
  logic ready;
  ffcss_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ffcss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/fat_free_cluster_sector_scrubber_unit.sv
// free-cluster scrubber for a FAT volume image
// channels: in (action, table_address, table_byte, sector_index, data_word,
// end_of_sector), out (data_out, zeroed, out_of_store, imaged_sectors,
// highest_used_cluster, sector_end), cfg (index, data) register writes
// a front stage takes beats into a two-entry queue; a back sequencer runs
// them one at a time against a table store with one write and one read port
// load: written to the table store when taken by the back part, no result beat
// filter: serial cluster divide, then up to four byte reads of the entry
// from the store
// report: N entries scanned downward from the top cluster, with two byte
// reads per entry for 12- and 16-bit entries and four for 32-bit entries
// the next item starts in the cycle after the result beat is taken
// reset clears control state and the registers to 1, 0, 1, 0, 0; the table
// store is not cleared and must be loaded before it is read
// when out stalls, the finished result beat is held and the back part
// waits; the queue keeps accepting until it is full
module fat_free_cluster_sector_scrubber_unit #(
  parameter int TABLE_BYTES = 1048576
) (
  input logic clk,
  input logic rst,
  ffcss_in_if.sink    in_ch,
  ffcss_out_if.source out_ch,
  ffcss_cfg_if.sink   cfg_ch
);
  ffcss_pkg::cfg_t        cfg;
  ffcss_pkg::queue_item_t q_head;
  logic                   q_full;
  logic                   q_ne;
  logic                   q_pop;
  logic                   q_push;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_code <= 2'd1;
      cfg.first_data <= 32'd0;
      cfg.spc <= 8'd1;
      cfg.count <= 28'd0;
      cfg.total <= 32'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ffcss_pkg::REG_WIDTH_CODE: cfg.width_code <= cfg_ch.data[1:0];
        ffcss_pkg::REG_FIRST_DATA: cfg.first_data <= cfg_ch.data;
        ffcss_pkg::REG_SPC:        cfg.spc <= cfg_ch.data[7:0];
        ffcss_pkg::REG_COUNT:      cfg.count <= cfg_ch.data[27:0];
        ffcss_pkg::REG_TOTAL:      cfg.total <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // front: take beats, drop NOP actions
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full && (in_ch.payload.action != ffcss_pkg::ACT_NOP);

  ffcss_queue #(.WIDTH($bits(ffcss_pkg::queue_item_t))) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(in_ch.payload),
    .full(q_full), .pop(q_pop), .pop_data(q_head), .not_empty(q_ne)
  );

  ffcss_back #(.TABLE_BYTES(TABLE_BYTES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .item_valid(q_ne), .item(q_head), .item_pop(q_pop),
    .res_valid(out_ch.valid), .res(out_ch.payload), .res_ready(out_ch.ready)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_ne)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result beat dropped");
endmodule

>>> rtl/ffcss_ram.sv
module ffcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/ffcss_queue.sv
module ffcss_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = slots[rptr];

  // two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/ffcss_back.sv
module ffcss_back #(
  parameter int TABLE_BYTES = 1048576
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ffcss_pkg::cfg_t           cfg,
  input  logic                      item_valid,
  input  ffcss_pkg::queue_item_t    item,
  output logic                      item_pop,
  output logic                      res_valid,
  output ffcss_pkg::out_item_t      res,
  input  logic                      res_ready
);
  localparam int AW = $clog2(TABLE_BYTES);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]  state;
  logic        is_report;
  logic [63:0] word;
  logic        eos;
  logic [31:0] quot;
  logic [31:0] rem;
  logic [31:0] dividend;
  logic [5:0]  div_cnt;
  logic        pre_data;
  logic [29:0] clus;
  logic [33:0] off;
  logic [1:0]  bsel;
  logic [1:0]  bmax;
  logic [31:0] ent;
  logic        rd_pend;
  logic        beyond_f;
  logic [7:0]  rdata;
  logic [AW-1:0] raddr;
  logic        busy_out;
  logic [31:0] spcx;
  logic [32:0] rem_sub;
  logic [33:0] last_b;
  logic        found;

  assign spcx = (cfg.spc == 8'd0) ? 32'd1 : {24'd0, cfg.spc};
  assign rem_sub = {rem[30:0], dividend[31]} - {1'b0, spcx};

  ffcss_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_ram (
    .clk(clk),
    .we(item_pop && item.action == ffcss_pkg::ACT_LOAD &&
        {14'd0, item.table_address} < 34'(TABLE_BYTES)),
    .waddr(AW'({12'd0, item.table_address})),
    .wdata(item.table_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  // byte offset and last byte of the current cluster's entry
  always_comb begin
    unique case (cfg.width_code)
      ffcss_pkg::FMT_FAT12: begin
        off = {4'd0, clus} + {5'd0, clus[29:1]};
        bmax = 2'd1;
      end
      ffcss_pkg::FMT_FAT16: begin
        off = {3'd0, clus, 1'b0};
        bmax = 2'd1;
      end
      default: begin
        off = {2'd0, clus, 2'b00};
        bmax = 2'd3;
      end
    endcase
    last_b = off + {32'd0, bmax};
    raddr = AW'(off + {32'd0, bsel});
  end

  assign item_pop = (state == S_IDLE) && item_valid && !busy_out;
  assign res_valid = busy_out;

  // sequencer: divide for filters, downward entry scan for reports
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy_out <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (busy_out && res_ready) busy_out <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_pop) begin
            word <= item.data_word;
            eos <= item.end_of_sector;
            beyond_f <= 1'b0;
            found <= 1'b0;
            is_report <= (item.action == ffcss_pkg::ACT_REPORT);
            pre_data <= item.sector_index < cfg.first_data;
            dividend <= item.sector_index - cfg.first_data;
            rem <= 32'd0;
            div_cnt <= 6'd0;
            clus <= {2'd0, cfg.count} + 30'd1;
            if (item.action == ffcss_pkg::ACT_FILTER) state <= S_DIV;
            if (item.action == ffcss_pkg::ACT_REPORT) state <= S_READ;
            bsel <= 2'd0;
            rd_pend <= 1'b0;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          dividend <= {dividend[30:0], 1'b0};
          if (!rem_sub[32]) begin
            rem <= rem_sub[31:0];
            quot <= {quot[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], dividend[31]};
            quot <= {quot[30:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd31) begin
            state <= S_READ;
            clus <= 30'd2 + {quot[28:0], ~rem_sub[32]};
            // quotient of 2^28 or more is always past the cluster count
            if (quot[30:27] != 4'd0) pre_data <= 1'b1;
          end
        end
        S_READ: begin
          if (!is_report && (pre_data ||
              clus >= {2'd0, cfg.count} + 30'd2)) begin
            ent <= 32'hFFFF_FFFF;
            state <= S_OUT;
          end else if (is_report && clus < 30'd2) begin
            state <= S_OUT;
          end else if (last_b >= 34'(TABLE_BYTES)) begin
            beyond_f <= 1'b1;
            ent <= 32'd1;
            if (is_report) begin
              found <= 1'b1;
            end
            state <= S_OUT;
          end else begin
            // issue one byte read per cycle, collect each in the next cycle
            if (!rd_pend) begin
              rd_pend <= 1'b1;
              bsel <= 2'd1;
              ent <= 32'd0;
            end else begin
              ent[{bsel - 2'd1, 3'b000} +: 8] <= rdata;
              if (bsel - 2'd1 == bmax) begin
                rd_pend <= 1'b0;
                bsel <= 2'd0;
                state <= S_OUT;
              end else begin
                bsel <= bsel + 2'd1;
              end
            end
          end
        end
        default: begin
          // S_OUT: decode entry, then finish or step the scan
          logic [31:0] e;
          logic        nz;
          ffcss_pkg::out_item_t r;
          e = ent;
          nz = 1'b1;
          r = '0;
          if (!beyond_f && ent != 32'hFFFF_FFFF) begin
            unique case (cfg.width_code)
              ffcss_pkg::FMT_FAT12:
                e = clus[0] ? {20'd0, ent[15:4]} : {20'd0, ent[11:0] & ffcss_pkg::MASK12};
              ffcss_pkg::FMT_FAT16: e = {16'd0, ent[15:0]};
              default: e = {4'd0, ent[27:0] & ffcss_pkg::MASK28};
            endcase
            nz = (e != 32'd0);
          end
          if (is_report && !found && !beyond_f && clus >= 30'd2 && !nz) begin
            clus <= clus - 30'd1;
            state <= S_READ;
          end else if (!busy_out) begin
            busy_out <= 1'b1;
            r.out_of_store = beyond_f;
            if (is_report) begin
              logic [29:0] h;
              logic [40:0] im;
              h = (found || nz) && clus >= 30'd2 ? clus : 30'd0;
              im = (h >= 30'd2) ?
                   {9'd0, cfg.first_data} + {11'd0, h - 30'd1} * {33'd0, spcx[7:0]} :
                   {9'd0, cfg.first_data};
              r.imaged_sectors = (im > {9'd0, cfg.total}) ? cfg.total : im[31:0];
              r.highest_used_cluster = (h > {2'd0, ffcss_pkg::MASK28}) ?
                                       ffcss_pkg::MASK28 : h[27:0];
            end else begin
              r.zeroed = !beyond_f && !nz;
              r.data_out = (!beyond_f && !nz) ? 64'd0 : word;
              r.sector_end = eos;
            end
            res <= r;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

>>> tb/fat_free_cluster_sector_scrubber_unit_tb.sv
`timescale 1ns / 100ps

module fat_free_cluster_sector_scrubber_unit_tb;
  import ffcss_pkg::*;

  localparam int TABLE_BYTES = 1048576;
  localparam int WINDOW      = 512;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [31:0] ALL32 = 32'hFFFFFFFF;

  // free-cluster predictor: register copy, table copy and owed results
  class scrub_book;
    cfg_t        regs;
    logic [7:0]  bytes [int];
    out_item_t   owed [$];
    int          errors;

    function new();
      regs.width_code = FMT_FAT16;
      regs.first_data = '0;
      regs.spc        = 8'd1;
      regs.count      = '0;
      regs.total      = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_WIDTH_CODE: regs.width_code = d[1:0];
        REG_FIRST_DATA: regs.first_data = d;
        REG_SPC:        regs.spc        = d[7:0];
        REG_COUNT:      regs.count      = d[27:0];
        REG_TOTAL:      regs.total      = d;
        default: ;
      endcase
    endfunction

    function longint unsigned spc_eff();
      return (regs.spc == 0) ? 1 : regs.spc;
    endfunction

    // entry of cluster n; past set when its bytes leave the store
    function logic [31:0] entry_of(longint unsigned n, output bit past);
      longint unsigned off, last;
      logic [31:0] v;
      if (regs.width_code == FMT_FAT12) begin
        off = n + (n >> 1);
        last = off + 1;
      end else if (regs.width_code == FMT_FAT16) begin
        off = n * 2;
        last = off + 1;
      end else begin
        off = n * 4;
        last = off + 3;
      end
      past = (last >= TABLE_BYTES);
      if (past) return 32'd1;
      v = {bytes[int'(off + 1)], bytes[int'(off)]};
      if (regs.width_code == FMT_FAT12)
        return n[0] ? (v >> 4) : (v & MASK12);
      if (regs.width_code == FMT_FAT16)
        return v;
      v = {bytes[int'(off + 3)], bytes[int'(off + 2)], v[15:0]};
      return v & MASK28;
    endfunction

    function void note_beat(in_item_t it);
      out_item_t res;
      longint unsigned cl, top, used, n, img;
      logic [31:0] e;
      bit past, flag;
      res = '0;
      past = 0;
      flag = 0;
      case (it.action)
        ACT_LOAD: begin
          bytes[int'(it.table_address)] = it.table_byte;
        end
        ACT_FILTER: begin
          res.data_out = it.data_word;
          res.sector_end = it.end_of_sector;
          if (it.sector_index >= regs.first_data) begin
            cl = 2 + (longint'(it.sector_index) - longint'(regs.first_data)) / spc_eff();
            if (cl < longint'(regs.count) + 2) begin
              e = entry_of(cl, past);
              if (!past && e == 0) begin
                res.data_out = '0;
                res.zeroed = 1'b1;
              end
            end
          end
          res.out_of_store = past;
          owed.push_back(res);
        end
        ACT_REPORT: begin
          top = longint'(regs.count) + 1;
          used = 0;
          // downward scan, first used entry is the highest
          for (n = top; n >= 2; n--) begin
            e = entry_of(n, past);
            if (past) flag = 1;
            if (e != 0) begin
              used = n;
              break;
            end
          end
          img = regs.first_data;
          if (used >= 2) img = img + (used - 1) * spc_eff();
          if (img > regs.total) img = regs.total;
          res.out_of_store = flag;
          res.imaged_sectors = img[31:0];
          res.highest_used_cluster = (used > MASK28) ? MASK28 : used[27:0];
          owed.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      string bad;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = owed.pop_front();
      bad = "";
      if (got.data_out !== want.data_out) bad = {bad, " data_out"};
      if (got.zeroed !== want.zeroed) bad = {bad, " zeroed"};
      if (got.out_of_store !== want.out_of_store) bad = {bad, " out_of_store"};
      if (got.imaged_sectors !== want.imaged_sectors) bad = {bad, " imaged_sectors"};
      if (got.highest_used_cluster !== want.highest_used_cluster)
        bad = {bad, " highest_used_cluster"};
      if (got.sector_end !== want.sector_end) bad = {bad, " sector_end"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) $display("result mismatch in%s: expected %p, got %p", bad, want, got);
      end
    endfunction

    function void close();
      if (owed.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", owed.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ffcss_in_if  in_ch ();
  ffcss_out_if out_ch ();
  ffcss_cfg_if cfg_ch ();

  scrub_book book;
  int src_idle;
  int snk_idle;
  int accepted;
  int cycles;
  bit held;

  fat_free_cluster_sector_scrubber_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result sampling
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) book.check_beat(out_ch.payload);
  end

  // result side back-pressure, with one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!rst && !held && accepted >= 700) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (499) @(negedge clk);
      end else begin
        out_ch.ready <= !rst && ($urandom_range(99) >= snk_idle);
      end
    end
  end

  function automatic in_item_t beat(logic [1:0] act, logic [19:0] addr, logic [7:0] byt,
                                    logic [31:0] sec, logic [63:0] word, logic eos);
    in_item_t it;
    it.action = act;
    it.table_address = addr;
    it.table_byte = byt;
    it.sector_index = sec;
    it.data_word = word;
    it.end_of_sector = eos;
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    book.note_beat(it);
    accepted++;
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    book.write_reg(idx, d);
    @(negedge clk);
  endtask

  // drain all owed results, then let queued loads finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (book.owed.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] wc, fds, spc, cnt, tot);
    reg_write(REG_WIDTH_CODE, wc);
    reg_write(REG_FIRST_DATA, fds);
    reg_write(REG_SPC, spc);
    reg_write(REG_COUNT, cnt);
    reg_write(REG_TOTAL, tot);
    cfg_ch.valid <= 1'b0;
  endtask

  // sector that never reaches an unwritten table entry
  function automatic logic [31:0] pick_sector();
    longint unsigned spc, fds, cnt, hi, fb, cl, s64;
    spc = book.spc_eff();
    fds = book.regs.first_data;
    cnt = book.regs.count;
    case (book.regs.width_code)
      FMT_FAT12: begin hi = 340; fb = 699050; end
      FMT_FAT16: begin hi = 255; fb = 524288; end
      default:   begin hi = 127; fb = 262144; end
    endcase
    if (cnt + 1 < hi) hi = cnt + 1;
    forever begin
      case ($urandom_range(3))
        0: if (fds > 0) return $urandom_range(32'(fds - 1), 0);
        1: if (hi >= 2) begin
          cl = $urandom_range(32'(hi), 2);
          s64 = fds + (cl - 2) * spc + $urandom_range(32'(spc - 1), 0);
          if (s64 <= ALL32) return s64[31:0];
        end
        2: if (cnt + 1 >= fb) begin
          cl = fb + $urandom_range(32'(cnt + 1 - fb), 0);
          s64 = fds + (cl - 2) * spc + $urandom_range(32'(spc - 1), 0);
          if (s64 <= ALL32) return s64[31:0];
        end
        default: begin
          s64 = fds + cnt * spc;
          if (s64 <= ALL32) begin
            if ($urandom_range(1)) return $urandom_range(ALL32, 32'(s64));
            return 32'(s64) + $urandom_range(32'(ALL32 - s64) < 300 ? 32'(ALL32 - s64) : 300, 0);
          end
        end
      endcase
    end
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t it;
    int r;
    it = beat(2'($urandom), 20'($urandom), 8'($urandom), $urandom,
              {$urandom, $urandom}, 1'($urandom));
    r = $urandom_range(99);
    if (r < 22) begin
      it.action = ACT_LOAD;
      it.table_address = $urandom_range(WINDOW - 1, 0);
      if ($urandom_range(1)) it.table_byte = '0;
    end else if (r < 26) begin
      it.action = ACT_LOAD;
    end else if (r < 30) begin
      it.action = ACT_NOP;
    end else if (r < 40) begin
      it.action = ACT_REPORT;
    end else begin
      it.action = ACT_FILTER;
      it.sector_index = pick_sector();
    end
    return it;
  endfunction

  initial begin
    logic [31:0] sv [5];
    logic [7:0] b;
    bit zero_group;
    book = new();
    cycles = 0;
    accepted = 0;
    src_idle = 7;
    snk_idle = 46;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, no cluster in range: nothing reads the table
    send_beat(beat(ACT_FILTER, '0, '0, '0, '1, 1'b1));
    send_beat(beat(ACT_FILTER, '1, '1, ALL32, '0, 1'b0));
    send_beat(beat(ACT_REPORT, '0, '0, '0, '0, 1'b0));
    send_beat(beat(ACT_NOP, '1, '1, ALL32, '1, 1'b1));

    // table window preload, whole groups of zeros give free entries
    for (int a = 0; a < WINDOW; a++) begin
      if (a % 4 == 0) zero_group = ($urandom_range(99) < 40);
      b = zero_group ? 8'h00 : 8'($urandom);
      send_beat(beat(ACT_LOAD, 20'(a), b, $urandom, {$urandom, $urandom}, 1'($urandom)));
    end

    // no used cluster, free-cluster zeroing, top address load
    settle();
    reg_write(REG_COUNT, 32'd3);
    cfg_ch.valid <= 1'b0;
    for (int a = 4; a < 10; a++)
      send_beat(beat(ACT_LOAD, 20'(a), 8'h00, '0, '0, 1'b0));
    send_beat(beat(ACT_REPORT, '0, '0, '0, '0, 1'b0));
    send_beat(beat(ACT_FILTER, '0, '0, 32'd0, 64'hDEADBEEFCAFEF00D, 1'b1));
    send_beat(beat(ACT_FILTER, '0, '0, 32'd2, '1, 1'b0));
    send_beat(beat(ACT_LOAD, 20'hFFFFF, 8'hFF, '0, '0, 1'b0));
    send_beat(beat(ACT_FILTER, '0, '0, ALL32, '1, 1'b1));

    // random phases over a spread of volume layouts
    for (int s = 0; s < 10; s++) begin
      settle();
      if (s == 4) begin
        src_idle = 46;
        snk_idle = 7;
      end else if (s == 7) begin
        src_idle = 0;
        snk_idle = 0;
      end
      case (s)
        0: sv = '{FMT_FAT16, 32'd10, 32'd1, 32'd200, ALL32};
        1: sv = '{FMT_FAT12, 32'd0, 32'd4, 32'd300, 32'd500};
        2: sv = '{32'd2, 32'hFFFFFF00, 32'd128, 32'd100, ALL32};
        3: sv = '{32'd3, 32'd7, 32'h00000100, 32'd50, 32'd0};
        4: sv = '{32'd2, 32'd3, 32'd2, ALL32, $urandom};
        5: sv = '{FMT_FAT16, 32'd1000, 32'd8, 32'd600000, 32'd2000000};
        6: sv = '{FMT_FAT12, 32'd0, 32'd1, 32'h0FFFFFF5, $urandom};
        7: sv = '{FMT_FAT16, 32'd0, 32'd1, 32'd0, 32'd0};
        8: sv = '{32'd2, 32'd100, 32'd64, 32'd1, 32'd150};
        default: sv = '{FMT_FAT12, 32'd2, 32'd3, 32'd10, 32'd40};
      endcase
      apply_setting(sv[0], sv[1], sv[2], sv[3], sv[4]);
      repeat (120) send_beat(rand_beat());
    end

    settle();
    repeat (100) @(negedge clk);
    book.close();
    if (book.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
